// ----- src/cfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the byte-wise CRC-16/MODBUS update for the
// four-channel frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

  localparam int unsigned NUM_CH      = 4;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned DATA_LEN    = 8;   // sample bytes per frame
  localparam int unsigned FRAME_LEN   = 10;  // sample bytes plus two CRC bytes
  localparam int unsigned SAMPLES_W   = NUM_CH * SAMPLE_W;
  localparam int unsigned FRAME_W     = FRAME_LEN * 8;
  localparam int unsigned CNT_W       = 4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);

  // Samples traveling down the CRC pipeline with the running CRC
  typedef struct packed {
    logic [SAMPLES_W-1:0] samples;
    logic [15:0]          crc;
  } stage_t;

  // One byte through the reflected CRC: eight LSB-first shift/xor steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- src/cfb_crc_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfb_crc_pipe
// Eight-stage elastic pipeline; stage k folds sample byte k into the CRC.
// ----------------------------------------------------------------------------
module cfb_crc_pipe (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_vld,
  output logic                                in_rdy,
  input  logic [cfb_pkg::SAMPLES_W-1:0]       in_samples,
  output logic                                out_vld,
  input  logic                                out_rdy,
  output cfb_pkg::stage_t                     out_stage
);

  localparam int unsigned NSTG = cfb_pkg::DATA_LEN;

  cfb_pkg::stage_t stg_r [NSTG];
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   rdy;

  // Backpressure: a stage takes new data when empty or when it drains
  assign rdy[NSTG] = out_rdy;

  genvar k;
  generate
    for (k = 0; k < NSTG; k++) begin : g_stage
      logic            prv_vld;
      cfb_pkg::stage_t prv;
      logic [15:0]     crc_nxt;

      assign rdy[k] = !vld_r[k] || rdy[k+1];

      if (k == 0) begin : g_first
        assign prv_vld = in_vld;
        assign prv     = '{samples: in_samples, crc: cfb_pkg::CRC_INIT};
      end else begin : g_rest
        assign prv_vld = vld_r[k-1];
        assign prv     = stg_r[k-1];
      end

      assign crc_nxt = cfb_pkg::crc16_byte(prv.crc, prv.samples[8*k +: 8]);

      // Valid bit
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld_r[k] <= prv_vld;
        end
      end

      // Payload
      always_ff @(posedge clk) begin
        if (rdy[k] && prv_vld) begin
          stg_r[k].samples <= prv.samples;
          stg_r[k].crc     <= crc_nxt;
        end
      end
    end
  endgenerate

  assign in_rdy    = rdy[0];
  assign out_vld   = vld_r[NSTG-1];
  assign out_stage = stg_r[NSTG-1];

endmodule

// ----- src/four_channel_crc16_frame_builder_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_channel_crc16_frame_builder_top
// Builds a 10-byte frame of four 16-bit samples plus CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one transaction carries four channel samples.
//   Output stream (out_*): ten byte transactions per input, channel 0 low
//   byte first, each sample low then high byte, then CRC low and CRC high;
//   out_tlast marks the CRC high byte.
//   Path: each input transaction passes through the eight CRC stages (one
//   sample byte each), then the serializer loads it into the shift register
//   that presents the first byte of the frame.
//   Output: the one-byte port sends each frame byte by byte; the next frame
//   loads in the cycle its predecessor's last byte leaves, so frames follow
//   with no gap. Up to eight more sample sets queue in the CRC pipeline
//   while a frame is being sent.
//   Reset (rst_n low, synchronous) empties the pipeline and the serializer.
//   A stalled receiver holds the current byte; the pipeline fills and then
//   in_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module four_channel_crc16_frame_builder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // channel_0[15:0], channel_1, channel_2, channel_3
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // frame_byte[7:0]
  output logic        out_tlast   // frame_end
);

  logic                     pipe_vld;
  logic                     pipe_rdy;
  cfb_pkg::stage_t          pipe_stage;

  logic                     busy_r;
  logic [cfb_pkg::FRAME_W-1:0] shift_r;
  logic [cfb_pkg::CNT_W-1:0]   cnt_r;
  logic [cfb_pkg::CNT_W-1:0]   cnt_nxt;
  logic                     out_hs;
  logic                     load;

  // CRC pipeline
  cfb_crc_pipe u_crc_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_tvalid),
    .in_rdy     (in_tready),
    .in_samples (in_tdata),
    .out_vld    (pipe_vld),
    .out_rdy    (pipe_rdy),
    .out_stage  (pipe_stage)
  );

  // Serializer control
  assign out_hs   = busy_r && out_tready;
  assign pipe_rdy = !busy_r || (out_tready && out_tlast);
  assign load     = pipe_vld && pipe_rdy;
  assign cnt_nxt  = cnt_r + {{(cfb_pkg::CNT_W-1){1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (out_hs) begin
      busy_r <= !out_tlast;
      cnt_r  <= out_tlast ? '0 : cnt_nxt;
    end
  end

  // Frame shift register, byte 0 in the low bits
  always_ff @(posedge clk) begin
    if (load) begin
      shift_r <= {pipe_stage.crc, pipe_stage.samples};
    end else if (out_hs) begin
      shift_r <= shift_r >> 8;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = shift_r[7:0];
  assign out_tlast  = (cnt_r == cfb_pkg::LAST_IDX);

  // Assertions
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cfb_pkg::LAST_IDX)
    else $error("byte counter beyond frame length");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_tvalid && cnt_r == '0))
    else $error("frame load did not start at byte 0");

  a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_hs && !out_tlast) |=> (out_tvalid && cnt_r == $past(cnt_nxt)))
    else $error("frame dropped before its last byte");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (cnt_r == '0))
    else $error("idle serializer holds a byte count");

endmodule
